### sv/dmr_pkg.sv
`timescale 1ns / 1ps

package dmr_pkg;

	localparam int DEF_MAX_WIDTH  = 256;
	localparam int DEF_MAX_HEIGHT = 256;
	localparam int DEF_MAX_WINDOW = 256;
	localparam int DEF_FRAC_BITS  = 6;

	localparam int NUM_COLORS  = 3;
	localparam int CFG_W       = 9;
	localparam int POS_W       = 8;
	localparam int COL_W       = 8;
	localparam int SHIFT_W     = 16;
	localparam int SH_ADDR_W   = 17;
	localparam int QUEUE_DEPTH = 4;
	localparam int PEND_MAX    = 10;

	localparam logic [CFG_W-1:0] WIDTH_RST  = 9'd256;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 9'd256;
	localparam logic [CFG_W-1:0] SIDE_RST   = 9'd230;

	localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [1:0] REG_WINDOW_SIDE  = 2'd2;

	localparam logic [1:0] REQ_PIXEL = 2'd0;
	localparam logic [1:0] REQ_SHIFT = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	typedef enum logic [1:0] {
		K_PIX,
		K_SHIFT,
		K_ZERO,
		K_QUERY
	} kind_t;

	typedef struct packed {
		logic [1:0]               req_type;
		logic [POS_W-1:0]         pos_x;
		logic [POS_W-1:0]         pos_y;
		logic [COL_W-1:0]         in_red;
		logic [COL_W-1:0]         in_green;
		logic [COL_W-1:0]         in_blue;
		logic signed [SHIFT_W-1:0] shift_x;
		logic signed [SHIFT_W-1:0] shift_y;
	} in_item_t;

	typedef struct packed {
		logic [COL_W-1:0] out_red;
		logic [COL_W-1:0] out_green;
		logic [COL_W-1:0] out_blue;
	} out_item_t;

	typedef struct packed {
		logic [1:0]       addr;
		logic [CFG_W-1:0] wdata;
	} cfg_item_t;

	typedef struct packed {
		kind_t                    kind;
		logic [POS_W-1:0]         pos_x;
		logic [POS_W-1:0]         pos_y;
		logic [3*COL_W-1:0]       rgb;
		logic [2*SHIFT_W-1:0]     shift;
		logic [SH_ADDR_W-1:0]     sh_addr;
		logic                     in_win;
	} cmd_t;

	typedef struct packed {
		logic [CFG_W-1:0] w_max;
		logic [CFG_W-1:0] h_max;
	} geom_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [CFG_W-1:0] sat_size(input logic [CFG_W-1:0] v, input int hi);
		if (v == '0) return CFG_W'(1);
		if (int'(v) > hi) return CFG_W'(hi);
		return v;
	endfunction

endpackage

### sv/dmr_chan_if.sv
`timescale 1ns / 1ps

interface dmr_chan_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### sv/dmr_ram.sv
`timescale 1ns / 1ps

module dmr_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### sv/dmr_front.sv
`timescale 1ns / 1ps

module dmr_front #(
	parameter int MAX_WIDTH  = dmr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dmr_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WINDOW = dmr_pkg::DEF_MAX_WINDOW
) (
	input  logic              clk,
	input  logic              arst_n,
	dmr_chan_if.sink          item,
	dmr_chan_if.sink          cfg,
	input  logic              busy,
	input  dmr_pkg::q_status_t qstat,
	output logic              push,
	output dmr_pkg::cmd_t     cmd,
	output dmr_pkg::geom_t    geom
);
	import dmr_pkg::*;

	logic [CFG_W-1:0] width_q, height_q, side_q;
	logic [CFG_W-1:0] w_eff, h_eff, s_eff, x0, y0;
	logic [CFG_W:0]   x_end, y_end;
	logic [CFG_W-1:0] xq, yq;
	logic             in_win, keep;
	logic [POS_W-1:0] row, col;
	kind_t            kind;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			side_q   <= SIDE_RST;
		end else if (cfg.valid) begin
			case (cfg.data.addr)
				REG_IMAGE_WIDTH:  width_q  <= cfg.data.wdata;
				REG_IMAGE_HEIGHT: height_q <= cfg.data.wdata;
				REG_WINDOW_SIDE:  side_q   <= cfg.data.wdata;
				default: ;
			endcase
		end
	end

	assign w_eff = sat_size(width_q, MAX_WIDTH);
	assign h_eff = sat_size(height_q, MAX_HEIGHT);
	assign s_eff = sat_size(side_q, MAX_WINDOW);

	// The window sits centred, with its origin rounded down.
	assign x0    = (w_eff > s_eff) ? ((w_eff - s_eff) >> 1) : '0;
	assign y0    = (h_eff > s_eff) ? ((h_eff - s_eff) >> 1) : '0;
	assign x_end = {1'b0, x0} + {1'b0, s_eff};
	assign y_end = {1'b0, y0} + {1'b0, s_eff};

	assign xq = CFG_W'(item.data.pos_x);
	assign yq = CFG_W'(item.data.pos_y);

	assign in_win = (xq >= x0) && ({1'b0, xq} < x_end) &&
	                (yq >= y0) && ({1'b0, yq} < y_end);

	assign geom.w_max = w_eff - CFG_W'(1);
	assign geom.h_max = h_eff - CFG_W'(1);

	assign item.ready = !qstat.full && !busy;

	always_comb begin
		keep = 1'b0;
		kind = K_QUERY;
		row  = item.data.pos_y;
		col  = item.data.pos_x;
		case (item.data.req_type)
			REQ_PIXEL: begin
				keep = (int'(item.data.pos_x) < MAX_WIDTH) &&
				       (int'(item.data.pos_y) < MAX_HEIGHT);
				kind = K_PIX;
			end
			REQ_SHIFT: begin
				keep = (xq < s_eff) && (yq < s_eff);
				kind = K_SHIFT;
			end
			REQ_QUERY: begin
				keep = 1'b1;
				kind = ((xq >= w_eff) || (yq >= h_eff)) ? K_ZERO : K_QUERY;
				row  = item.data.pos_y - y0[POS_W-1:0];
				col  = item.data.pos_x - x0[POS_W-1:0];
			end
			default: keep = 1'b0;
		endcase
	end

	assign cmd.kind    = kind;
	assign cmd.pos_x   = item.data.pos_x;
	assign cmd.pos_y   = item.data.pos_y;
	assign cmd.rgb     = {item.data.in_blue, item.data.in_green, item.data.in_red};
	assign cmd.shift   = {item.data.shift_y, item.data.shift_x};
	assign cmd.in_win  = in_win;
	assign cmd.sh_addr = SH_ADDR_W'(row) * SH_ADDR_W'(s_eff) + SH_ADDR_W'(col);

	assign push = item.valid && item.ready && keep;
endmodule

### sv/dmr_fifo.sv
`timescale 1ns / 1ps

module dmr_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dmr_pkg::cmd_t      wr_cmd,
	input  logic               pop,
	output dmr_pkg::cmd_t      head,
	output dmr_pkg::q_status_t qstat
);
	import dmr_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_cmd;
		end
	end

	assign head        = mem_q[rd_q];
	assign qstat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (cnt_q == '0);
endmodule

### sv/dmr_back.sv
`timescale 1ns / 1ps

module dmr_back #(
	parameter int MAX_WIDTH  = dmr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dmr_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WINDOW = dmr_pkg::DEF_MAX_WINDOW,
	parameter int FRAC_BITS  = dmr_pkg::DEF_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dmr_pkg::cmd_t      head,
	input  dmr_pkg::q_status_t qstat,
	input  dmr_pkg::geom_t     geom,
	output logic               pop,
	output logic               busy,
	dmr_chan_if.source         result
);
	import dmr_pkg::*;

	localparam int XS   = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
	localparam int YS   = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
	localparam int XB   = $clog2(XS);
	localparam int YB   = $clog2(YS);
	localparam int XBA  = (XB > 1) ? XB - 1 : 1;
	localparam int YBA  = (YB > 1) ? YB - 1 : 1;
	localparam int BANK_DEPTH = 1 << (XBA + YBA);
	localparam int PIX_DEPTH  = 1 << (XB + YB);
	localparam int SIDE_MAX   = (MAX_WINDOW < 511) ? MAX_WINDOW : 511;
	localparam int ROWS       = (SIDE_MAX < 256) ? SIDE_MAX : 256;
	localparam int SH_DEPTH   = ROWS * SIDE_MAX;
	localparam int SAW        = $clog2(SH_DEPTH);
	localparam int ONE        = 1 << FRAC_BITS;
	localparam int PW         = (((POS_W + FRAC_BITS) > SHIFT_W) ?
	                            (POS_W + FRAC_BITS) : SHIFT_W) + 2;
	localparam int TW         = COL_W + FRAC_BITS;
	localparam int VW         = COL_W + 2 * FRAC_BITS + 1;
	localparam int PXW        = 3 * COL_W;

	function automatic logic [CFG_W-1:0] clamp_c(input logic signed [PW-1:0] v,
	                                             input logic [CFG_W-1:0] hi);
		if (v < 0) return '0;
		if (v > signed'(PW'(hi))) return hi;
		return CFG_W'(v);
	endfunction

	logic en;
	logic out_v_q;
	out_item_t out_q;

	// Shift table clearing after reset.
	logic [SAW-1:0] clr_q;
	logic           busy_q;

	logic                 sh_we;
	logic [SAW-1:0]       sh_waddr;
	logic [2*SHIFT_W-1:0] sh_wdata, sh_rdata;

	// Stage two: the displacement entry has arrived.
	logic v_s2;
	cmd_t cmd_s2;
	logic signed [SHIFT_W-1:0] dx, dy;
	logic signed [PW-1:0]      px, py, nx, ny, nx1, ny1;
	logic interp;

	// Stage three: pixel store access.
	logic v_s3;
	cmd_t cmd_s3;
	logic interp_s3;
	logic [CFG_W-1:0] xa_s3, xb_s3, ya_s3, yb_s3;
	logic [FRAC_BITS-1:0] fx_s3, fy_s3;
	logic pix_we;
	logic [XB+YB-1:0] pix_addr;
	logic [PXW-1:0] pass_rd;
	logic [PXW-1:0] bank_rd [4];

	// Stage four: first interpolation pass.
	logic v_s4;
	kind_t kind_s4;
	logic interp_s4;
	logic [FRAC_BITS-1:0] fx_s4, fy_s4;
	logic xa0_s4, xb0_s4, ya0_s4, yb0_s4;
	logic [PXW-1:0] p00, p01, p10, p11;
	logic [TW-1:0] top_c [NUM_COLORS];
	logic [TW-1:0] bot_c [NUM_COLORS];

	// Stage five: second interpolation pass.
	logic v_s5;
	kind_t kind_s5;
	logic interp_s5;
	logic [FRAC_BITS-1:0] fy_s5;
	logic [PXW-1:0] pass_s5;
	logic [TW-1:0] top_s5 [NUM_COLORS];
	logic [TW-1:0] bot_s5 [NUM_COLORS];
	out_item_t res_c;

	assign en   = !out_v_q || result.ready;
	assign pop  = en && !qstat.empty;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			clr_q <= clr_q + SAW'(1);
			if (clr_q == SAW'(SH_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign sh_we    = busy_q || (pop && head.kind == K_SHIFT);
	assign sh_waddr = busy_q ? clr_q : head.sh_addr[SAW-1:0];
	assign sh_wdata = busy_q ? '0 : head.shift;

	dmr_ram #(.WIDTH(2 * SHIFT_W), .DEPTH(SH_DEPTH)) u_shift_ram (
		.clk   (clk),
		.we    (sh_we),
		.waddr (sh_waddr),
		.wdata (sh_wdata),
		.re    (en),
		.raddr (head.sh_addr[SAW-1:0]),
		.rdata (sh_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			v_s5    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (en) begin
			v_s2    <= !qstat.empty;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			v_s5    <= v_s4;
			out_v_q <= v_s5 && (kind_s5 == K_ZERO || kind_s5 == K_QUERY);
		end
	end

	assign dx = signed'(sh_rdata[SHIFT_W-1:0]);
	assign dy = signed'(sh_rdata[2*SHIFT_W-1:SHIFT_W]);
	assign interp = (cmd_s2.kind == K_QUERY) && cmd_s2.in_win && (dx != 0 || dy != 0);

	// An arithmetic shift gives the floor, so the fraction is never negative.
	assign px  = PW'({cmd_s2.pos_x, {FRAC_BITS{1'b0}}}) + PW'(dx);
	assign py  = PW'({cmd_s2.pos_y, {FRAC_BITS{1'b0}}}) + PW'(dy);
	assign nx  = px >>> FRAC_BITS;
	assign ny  = py >>> FRAC_BITS;
	assign nx1 = nx + PW'(1);
	assign ny1 = ny + PW'(1);

	assign pix_we   = en && v_s3 && cmd_s3.kind == K_PIX;
	assign pix_addr = {cmd_s3.pos_y[YB-1:0], cmd_s3.pos_x[XB-1:0]};

	dmr_ram #(.WIDTH(PXW), .DEPTH(PIX_DEPTH)) u_pass_ram (
		.clk   (clk),
		.we    (pix_we),
		.waddr (pix_addr),
		.wdata (cmd_s3.rgb),
		.re    (en),
		.raddr (pix_addr),
		.rdata (pass_rd)
	);

	// Unless clamping makes them coincide, the four neighbours fall in four different parity banks.
	for (genvar b = 0; b < 4; b++) begin : g_bank
		localparam logic BX = 1'(b % 2);
		localparam logic BY = 1'(b / 2);
		logic [CFG_W-1:0] bcol, brow;
		logic [XBA+YBA-1:0] braddr, bwaddr;
		logic bwe;

		assign bcol   = (BX == xa_s3[0]) ? xa_s3 : xb_s3;
		assign brow   = (BY == ya_s3[0]) ? ya_s3 : yb_s3;
		assign braddr = {YBA'(brow[YB-1:0] >> 1), XBA'(bcol[XB-1:0] >> 1)};
		assign bwaddr = {YBA'(cmd_s3.pos_y[YB-1:0] >> 1), XBA'(cmd_s3.pos_x[XB-1:0] >> 1)};
		assign bwe    = pix_we && cmd_s3.pos_x[0] == BX && cmd_s3.pos_y[0] == BY;

		dmr_ram #(.WIDTH(PXW), .DEPTH(BANK_DEPTH)) u_bank_ram (
			.clk   (clk),
			.we    (bwe),
			.waddr (bwaddr),
			.wdata (cmd_s3.rgb),
			.re    (en),
			.raddr (braddr),
			.rdata (bank_rd[b])
		);
	end

	assign p00 = bank_rd[{ya0_s4, xa0_s4}];
	assign p01 = bank_rd[{ya0_s4, xb0_s4}];
	assign p10 = bank_rd[{yb0_s4, xa0_s4}];
	assign p11 = bank_rd[{yb0_s4, xb0_s4}];

	always_comb begin
		logic [FRAC_BITS:0] wx;
		logic [TW:0]        t0, t1, b0, b1;
		wx = (FRAC_BITS + 1)'(ONE) - (FRAC_BITS + 1)'(fx_s4);
		for (int c = 0; c < NUM_COLORS; c++) begin
			t0 = (TW + 1)'(p00[c*COL_W +: COL_W]) * (TW + 1)'(wx);
			t1 = (TW + 1)'(p01[c*COL_W +: COL_W]) * (TW + 1)'(fx_s4);
			b0 = (TW + 1)'(p10[c*COL_W +: COL_W]) * (TW + 1)'(wx);
			b1 = (TW + 1)'(p11[c*COL_W +: COL_W]) * (TW + 1)'(fx_s4);
			top_c[c] = TW'(t0 + t1);
			bot_c[c] = TW'(b0 + b1);
		end
	end

	always_comb begin
		logic [FRAC_BITS:0] wy;
		logic [VW-1:0]      v;
		logic [PXW-1:0]     pix;
		wy  = (FRAC_BITS + 1)'(ONE) - (FRAC_BITS + 1)'(fy_s5);
		pix = pass_s5;
		for (int c = 0; c < NUM_COLORS; c++) begin
			v = VW'(top_s5[c]) * VW'(wy) + VW'(bot_s5[c]) * VW'(fy_s5);
			if (interp_s5) begin
				pix[c*COL_W +: COL_W] = v[2*FRAC_BITS +: COL_W];
			end
		end
		if (kind_s5 == K_ZERO) begin
			pix = '0;
		end
		res_c.out_red   = pix[0 +: COL_W];
		res_c.out_green = pix[COL_W +: COL_W];
		res_c.out_blue  = pix[2*COL_W +: COL_W];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s2 <= head;

			cmd_s3    <= cmd_s2;
			interp_s3 <= interp;
			xa_s3     <= clamp_c(nx, geom.w_max);
			xb_s3     <= clamp_c(nx1, geom.w_max);
			ya_s3     <= clamp_c(ny, geom.h_max);
			yb_s3     <= clamp_c(ny1, geom.h_max);
			fx_s3     <= px[FRAC_BITS-1:0];
			fy_s3     <= py[FRAC_BITS-1:0];

			kind_s4   <= cmd_s3.kind;
			interp_s4 <= interp_s3;
			fx_s4     <= fx_s3;
			fy_s4     <= fy_s3;
			xa0_s4    <= xa_s3[0];
			xb0_s4    <= xb_s3[0];
			ya0_s4    <= ya_s3[0];
			yb0_s4    <= yb_s3[0];

			kind_s5   <= kind_s4;
			interp_s5 <= interp_s4;
			fy_s5     <= fy_s4;
			pass_s5   <= pass_rd;
			top_s5    <= top_c;
			bot_s5    <= bot_c;

			out_q <= res_c;
		end
	end

	assign result.valid = out_v_q;
	assign result.data  = out_q;
endmodule

### sv/displacement_map_bilinear_remap_top.sv
`timescale 1ns / 1ps

// Remaps an RGB image through a table of signed displacements with bilinear
// sampling. Items on the item channel load source pixels, load displacement
// entries or ask for one output pixel; only the last kind gives a transfer on
// the result channel, in the order the items arrived. One item is taken every
// clock cycle while results are taken; a query goes through the queue, the
// registered pipeline stages and the output register. The rate is set by
// the four parity banks of the pixel store, which deliver all four
// neighbours of a sample in a single read cycle. After reset the displacement
// table is cleared one entry a cycle, ROWS * SIDE_MAX entries (65536 with the
// default sizes), and no item is taken before that; configuration writes are
// taken at any time but must only be issued while the block is idle.

module displacement_map_bilinear_remap_top #(
	parameter int MAX_WIDTH  = dmr_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = dmr_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WINDOW = dmr_pkg::DEF_MAX_WINDOW,
	parameter int FRAC_BITS  = dmr_pkg::DEF_FRAC_BITS
) (
	input  logic       clk,
	input  logic       arst_n,
	dmr_chan_if.sink   item,
	dmr_chan_if.sink   cfg,
	dmr_chan_if.source result
);
	import dmr_pkg::*;

	logic      push, pop, busy;
	cmd_t      wr_cmd, head;
	geom_t     geom;
	q_status_t qstat;

	dmr_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WINDOW (MAX_WINDOW)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.busy   (busy),
		.qstat  (qstat),
		.push   (push),
		.cmd    (wr_cmd),
		.geom   (geom)
	);

	dmr_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.head   (head),
		.qstat  (qstat)
	);

	dmr_back #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WINDOW (MAX_WINDOW),
		.FRAC_BITS  (FRAC_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.qstat  (qstat),
		.geom   (geom),
		.pop    (pop),
		.busy   (busy),
		.result (result)
	);
endmodule

### sv/dmr_checker.sv
`timescale 1ns / 1ps

module dmr_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                item_valid,
	input logic                item_ready,
	input logic [1:0]          item_req,
	input logic                result_valid,
	input logic                result_ready,
	input dmr_pkg::out_item_t  result_data
);
	import dmr_pkg::*;

	logic [4:0] pending_q;

	// Queries taken but whose result has not yet been transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q
			           + 5'(item_valid && item_ready && item_req == REQ_QUERY)
			           - 5'(result_valid && result_ready);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result withdrawn before transfer");

	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> $stable(result_data))
		else $error("result payload changed while stalled");

	a_owed: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> pending_q != 5'd0)
		else $error("result offered with no query outstanding");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 5'(PEND_MAX))
		else $error("more queries in flight than the pipeline can hold");
endmodule

bind displacement_map_bilinear_remap_top dmr_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_req     (item.data.req_type),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

### dv/dmr_remap_checker.sv
`timescale 1ns / 1ps

module dmr_remap_checker (
	input  logic clk,
	input  logic arst_n,
	dmr_chan_if  item,
	dmr_chan_if  cfg,
	dmr_chan_if  result,
	output int   errors,
	output int   pending
);
	import dmr_pkg::*;

	localparam int ONE = 1 << DEF_FRAC_BITS;

	logic [3*COL_W-1:0]   pix_mem   [0:65535];
	logic [2*SHIFT_W-1:0] shift_mem [0:65535];
	logic [CFG_W-1:0]     reg_width;
	logic [CFG_W-1:0]     reg_height;
	logic [CFG_W-1:0]     reg_side;
	out_item_t            expected_pixels [$];

	assign pending = expected_pixels.size();

	function automatic int eff_size(logic [CFG_W-1:0] v, int hi);
		if (v == 0) return 1;
		if (int'(v) > hi) return hi;
		return int'(v);
	endfunction

	function automatic int clamp_to(int v, int hi);
		if (v < 0) return 0;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic int colour_of(logic [3*COL_W-1:0] p, int c);
		return int'((p >> (8 * c)) & 24'hFF);
	endfunction

	function automatic out_item_t remap_pixel(int x, int y);
		int w, h, s, x0, y0, dx, dy, px, py, nx, ny, fx, fy, xa, xb, ya, yb, c;
		int upper, lower;
		int val [3];
		logic [2*SHIFT_W-1:0] e;
		logic [3*COL_W-1:0] p00, p01, p10, p11, src;
		out_item_t o;
		w = eff_size(reg_width, DEF_MAX_WIDTH);
		h = eff_size(reg_height, DEF_MAX_HEIGHT);
		s = eff_size(reg_side, DEF_MAX_WINDOW);
		o = '0;
		if (x >= w || y >= h) return o;
		x0 = (w > s) ? (w - s) / 2 : 0;
		y0 = (h > s) ? (h - s) / 2 : 0;
		src = pix_mem[y * 256 + x];
		for (c = 0; c < 3; c++) val[c] = colour_of(src, c);
		if (x >= x0 && x < x0 + s && y >= y0 && y < y0 + s) begin
			e = shift_mem[(y - y0) * s + (x - x0)];
			dx = int'($signed(e[15:0]));
			dy = int'($signed(e[31:16]));
			if (dx != 0 || dy != 0) begin
				// Arithmetic shift floors toward minus infinity; the mask keeps the fraction.
				px = x * ONE + dx;
				py = y * ONE + dy;
				nx = px >>> DEF_FRAC_BITS;
				ny = py >>> DEF_FRAC_BITS;
				fx = px & (ONE - 1);
				fy = py & (ONE - 1);
				xa = clamp_to(nx, w - 1);
				xb = clamp_to(nx + 1, w - 1);
				ya = clamp_to(ny, h - 1);
				yb = clamp_to(ny + 1, h - 1);
				p00 = pix_mem[ya * 256 + xa];
				p01 = pix_mem[ya * 256 + xb];
				p10 = pix_mem[yb * 256 + xa];
				p11 = pix_mem[yb * 256 + xb];
				for (c = 0; c < 3; c++) begin
					upper = colour_of(p00, c) * (ONE - fx) + colour_of(p01, c) * fx;
					lower = colour_of(p10, c) * (ONE - fx) + colour_of(p11, c) * fx;
					val[c] = ((upper * (ONE - fy) + lower * fy) >> (2 * DEF_FRAC_BITS)) & 255;
				end
			end
		end
		o.out_red   = val[0][7:0];
		o.out_green = val[1][7:0];
		o.out_blue  = val[2][7:0];
		return o;
	endfunction

	// Signals are stable at the falling edge; a transfer seen here happens at the next rising edge.
	always @(negedge clk or negedge arst_n) begin
		in_item_t  it;
		cfg_item_t cw;
		out_item_t got;
		out_item_t want;
		int s;
		if (!arst_n) begin
			for (int i = 0; i < 65536; i++) shift_mem[i] = '0;
			reg_width  = WIDTH_RST;
			reg_height = HEIGHT_RST;
			reg_side   = SIDE_RST;
			errors     = 0;
			expected_pixels.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				cw = cfg.data;
				case (cw.addr)
					REG_IMAGE_WIDTH:  reg_width  = cw.wdata;
					REG_IMAGE_HEIGHT: reg_height = cw.wdata;
					REG_WINDOW_SIDE:  reg_side   = cw.wdata;
					default: ;
				endcase
			end
			if (item.valid && item.ready) begin
				it = item.data;
				s = eff_size(reg_side, DEF_MAX_WINDOW);
				case (it.req_type)
					REQ_PIXEL: pix_mem[{it.pos_y, it.pos_x}] = {it.in_blue, it.in_green, it.in_red};
					REQ_SHIFT: if (int'(it.pos_x) < s && int'(it.pos_y) < s)
						shift_mem[int'(it.pos_y) * s + int'(it.pos_x)] = {it.shift_y, it.shift_x};
					REQ_QUERY: expected_pixels.push_back(remap_pixel(int'(it.pos_x), int'(it.pos_y)));
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				got = result.data;
				if (expected_pixels.size() == 0) begin
					$error("unexpected result transfer %h", got);
					errors++;
				end else begin
					want = expected_pixels.pop_front();
					if (got.out_red !== want.out_red) begin
						$error("out_red expected %0d actual %0d", want.out_red, got.out_red);
						errors++;
					end
					if (got.out_green !== want.out_green) begin
						$error("out_green expected %0d actual %0d", want.out_green, got.out_green);
						errors++;
					end
					if (got.out_blue !== want.out_blue) begin
						$error("out_blue expected %0d actual %0d", want.out_blue, got.out_blue);
						errors++;
					end
				end
			end
		end
	end
endmodule

### dv/tb_displacement_map_bilinear_remap_top.sv
`timescale 1ns / 1ps

module tb_displacement_map_bilinear_remap_top;
	import dmr_pkg::*;

	localparam int STALL_LIMIT = 200000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int FILL_SIDE = 16;

	logic clk;
	logic arst_n;
	int   tx_idle_pct;
	int   rx_idle_pct;
	logic hold_go;
	logic hold_seen;
	int   hold_cnt;
	int   quiet_cycles;
	int   errors;
	int   pending;

	dmr_chan_if #(.data_t(in_item_t))  item_ch ();
	dmr_chan_if #(.data_t(cfg_item_t)) cfg_ch ();
	dmr_chan_if #(.data_t(out_item_t)) result_ch ();

	displacement_map_bilinear_remap_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	dmr_remap_checker i_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.cfg     (cfg_ch),
		.result  (result_ch),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result side: one long hold-off on request, otherwise random back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_seen       <= 1'b0;
			hold_cnt        <= 0;
		end else if (hold_go && !hold_seen) begin
			hold_seen       <= 1'b1;
			hold_cnt        <= 400;
			result_ch.ready <= 1'b0;
		end else if (hold_cnt > 0) begin
			hold_cnt        <= hold_cnt - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(negedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
		    (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic int eff_size(int v, int hi);
		if (v == 0) return 1;
		if (v > hi) return hi;
		return v;
	endfunction

	task automatic send_item(in_item_t it);
		logic took;
		while ($urandom_range(99) < tx_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		do begin
			@(negedge clk);
			took = item_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic wait_drained();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		// Loads give no result and may still be in flight.
		repeat (20) @(posedge clk);
	endtask

	// Leaves valid high; the caller drops it after the last write.
	task automatic write_reg(logic [1:0] idx, int value);
		logic took;
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= '{addr: idx, wdata: value[CFG_W-1:0]};
		do begin
			@(negedge clk);
			took = cfg_ch.ready;
			@(posedge clk);
		end while (!took);
	endtask

	function automatic in_item_t make_req(logic [1:0] kind, int x, int y, int dx, int dy);
		in_item_t it;
		it          = '0;
		it.req_type = kind;
		it.pos_x    = x[7:0];
		it.pos_y    = y[7:0];
		it.in_red   = 8'($urandom());
		it.in_green = 8'($urandom());
		it.in_blue  = 8'($urandom());
		it.shift_x  = dx[15:0];
		it.shift_y  = dy[15:0];
		return it;
	endfunction

	function automatic int rand_shift();
		int r;
		r = $urandom_range(99);
		if (r < 10) return 0;
		if (r < 60) return int'($urandom_range(400)) - 200;
		return int'($urandom_range(65535)) - 32768;
	endfunction

	function automatic in_item_t rand_req(int w, int h, int s);
		int r;
		int x;
		int y;
		r = $urandom_range(99);
		if (r < 20) return make_req(REQ_PIXEL, $urandom_range(255), $urandom_range(255), 0, 0);
		if (r < 45) begin
			x = ($urandom_range(99) < 85) ? $urandom_range(s - 1) : $urandom_range(255);
			y = ($urandom_range(99) < 85) ? $urandom_range(s - 1) : $urandom_range(255);
			return make_req(REQ_SHIFT, x, y, rand_shift(), rand_shift());
		end
		if (r < 95) begin
			x = ($urandom_range(99) < 80) ? $urandom_range(w - 1) : $urandom_range(255);
			y = ($urandom_range(99) < 80) ? $urandom_range(h - 1) : $urandom_range(255);
			return make_req(REQ_QUERY, x, y, rand_shift(), rand_shift());
		end
		return make_req(REQ_UNUSED, $urandom_range(255), $urandom_range(255),
		                rand_shift(), rand_shift());
	endfunction

	initial begin
		int widths  [7] = '{16, 1, 0, 16, 7, 16, 12};
		int heights [7] = '{12, 1, 16, 0, 16, 16, 5};
		int sides   [7] = '{5, 1, 300, 0, 16, 3, 1};
		int w;
		int h;
		int s;
		arst_n        = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.data  = '0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.data   = '0;
		hold_go       = 1'b0;
		tx_idle_pct   = 31;
		rx_idle_pct   = 58;
		quiet_cycles  = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Every image used below lies inside this corner, so no sample reads an unwritten pixel.
		for (int y = 0; y < FILL_SIDE; y++)
			for (int x = 0; x < FILL_SIDE; x++)
				send_item(make_req(REQ_PIXEL, x, y, 0, 0));

		wait_drained();
		write_reg(REG_IMAGE_WIDTH, 16);
		write_reg(REG_IMAGE_HEIGHT, 16);
		write_reg(REG_WINDOW_SIDE, 10);
		cfg_ch.valid <= 1'b0;

		// Window of 10 in a 16 image starts at 3.
		send_item(make_req(REQ_SHIFT, 0, 0, 32767, -32768));
		send_item(make_req(REQ_QUERY, 3, 3, 0, 0));
		send_item(make_req(REQ_SHIFT, 9, 9, -1, 1));
		send_item(make_req(REQ_QUERY, 12, 12, 0, 0));
		send_item(make_req(REQ_SHIFT, 1, 0, 0, 0));
		send_item(make_req(REQ_QUERY, 4, 3, 0, 0));
		send_item(make_req(REQ_SHIFT, 2, 0, -100, -100));
		send_item(make_req(REQ_QUERY, 5, 3, 0, 0));
		send_item(make_req(REQ_SHIFT, 3, 0, 5, 0));
		send_item(make_req(REQ_QUERY, 6, 3, 0, 0));
		send_item(make_req(REQ_SHIFT, 4, 0, 0, -32768));
		send_item(make_req(REQ_QUERY, 7, 3, 0, 0));
		send_item(make_req(REQ_SHIFT, 10, 5, 300, 300));
		send_item(make_req(REQ_SHIFT, 255, 255, -1, -1));
		send_item(make_req(REQ_QUERY, 0, 0, 0, 0));
		send_item(make_req(REQ_PIXEL, 15, 15, 0, 0));
		send_item(make_req(REQ_QUERY, 15, 15, 0, 0));
		send_item(make_req(REQ_PIXEL, 0, 0, 0, 0));
		send_item(make_req(REQ_QUERY, 0, 0, 0, 0));
		send_item(make_req(REQ_UNUSED, 255, 255, -1, -1));
		send_item(make_req(REQ_QUERY, 12, 3, 0, 0));
		send_item(make_req(REQ_QUERY, 16, 2, 0, 0));
		send_item(make_req(REQ_QUERY, 200, 200, 0, 0));

		for (int ph = 0; ph < 7; ph++) begin
			wait_drained();
			if (ph == 3) begin
				tx_idle_pct = 58;
				rx_idle_pct = 31;
			end else if (ph == 5) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			write_reg(REG_IMAGE_WIDTH, widths[ph]);
			write_reg(REG_IMAGE_HEIGHT, heights[ph]);
			write_reg(REG_WINDOW_SIDE, sides[ph]);
			cfg_ch.valid <= 1'b0;
			w = eff_size(widths[ph], DEF_MAX_WIDTH);
			h = eff_size(heights[ph], DEF_MAX_HEIGHT);
			s = eff_size(sides[ph], DEF_MAX_WINDOW);
			for (int n = 0; n < 45; n++) begin
				if (ph == 5 && n == 10) hold_go <= 1'b1;
				if (ph == 4 && n == 20) wait_drained();
				send_item(rand_req(w, h, s));
			end
		end

		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
